>>> rtl/dmxfs_pkg.sv
// ----------------------------------------------------------------------------
// dmxfs_pkg
// shared widths, result codes and register indexes of the frame statistics
// monitor
// ----------------------------------------------------------------------------
`default_nettype none

package dmxfs_pkg;

    localparam int UNIVERSE_W   = 32;
    localparam int SLOT_W       = 8;
    localparam int STATUS_W     = 2;
    localparam int TRK_IDX_W    = 2;
    localparam int COUNT_W      = 32;
    localparam int LEN_W        = 10;
    localparam int MASK_W       = 4;
    localparam int MAX_TRACKERS = 4;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_COUNTED = 2'd0,
        STATUS_ERROR   = 2'd1,
        STATUS_UNKNOWN = 2'd2
    } status_t;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_TRACKED_MASK = 3'd0;
    localparam cfg_index_t CFG_UNIVERSE_0   = 3'd1;
    localparam cfg_index_t CFG_UNIVERSE_3   = 3'd4;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/dmxfs_if.sv
// ----------------------------------------------------------------------------
// dmxfs channels
// valid/ready channels for slot bytes in and frame reports out
// ----------------------------------------------------------------------------
`default_nettype none

interface dmxfs_in_if;
    import dmxfs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [UNIVERSE_W-1:0] universe;
    logic [SLOT_W-1:0]     slot_value;
    logic                  last_slot;
    logic                  frame_error;

    modport source (output valid, cmd, universe, slot_value, last_slot, frame_error,
                    input ready);
    modport sink   (input valid, cmd, universe, slot_value, last_slot, frame_error,
                    output ready);
endinterface

interface dmxfs_out_if;
    import dmxfs_pkg::*;

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [TRK_IDX_W-1:0] tracker_index;
    logic [COUNT_W-1:0]   frames_seen;
    logic [COUNT_W-1:0]   changes_seen;
    logic [LEN_W-1:0]     shortest_length;
    logic [LEN_W-1:0]     longest_length;
    logic                 frame_changed;

    modport source (output valid, status, tracker_index, frames_seen, changes_seen,
                    shortest_length, longest_length, frame_changed,
                    input ready);
    modport sink   (input valid, status, tracker_index, frames_seen, changes_seen,
                    shortest_length, longest_length, frame_changed,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/dmxfs_store.sv
// ----------------------------------------------------------------------------
// dmxfs_store
// single-port frame byte memory, read-first, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dmxfs_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic                      clk,
    input  wire logic                      rd_en,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             addr,
    input  wire logic [dmxfs_pkg::SLOT_W-1:0] wdata,
    output logic      [dmxfs_pkg::SLOT_W-1:0] rdata
);
    import dmxfs_pkg::*;

    logic [SLOT_W-1:0] store_mem [DEPTH];
    logic [SLOT_W-1:0] rdata_reg;

    // old contents come out while the new byte goes in
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= store_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/dmx_frame_stats_monitor.sv
// ----------------------------------------------------------------------------
// dmx_frame_stats_monitor
// per-universe frame statistics: length range, frame count and change count,
// with the last frame of each tracked universe kept in a byte memory
// ----------------------------------------------------------------------------
//  port      | dir | handshake     | transaction
//  ----------+-----+---------------+-------------------------------------------
//  slots     | in  | valid/ready   | one slot byte, or a statistics clear
//  stats     | out | valid/ready   | one report per frame, on its last slot
//  cfg_*     | in  | cfg_we only   | register write, tracked mask or universe
//
//  one transaction per cycle in while slots is not stalled; after the last
//  slot of its frame is taken, a report passes the read-first frame memory
//  access, the compare and statistics update stage and the report register
//  reset is immediate: no memory clearing pass, stored lengths gate all reads
//  slots stall only while a finished report waits in the output register
//  and the compare stage holds another last slot
// ----------------------------------------------------------------------------
`default_nettype none

module dmx_frame_stats_monitor #(
    parameter int NUM_TRACKERS = 4,
    parameter int FRAME_SLOTS  = 512
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    dmxfs_in_if.sink                                slots,
    dmxfs_out_if.source                             stats,
    input  wire logic                               cfg_we,
    input  wire logic [dmxfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dmxfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dmxfs_pkg::*;

    localparam int TW    = (NUM_TRACKERS > 1) ? $clog2(NUM_TRACKERS) : 1;
    localparam int LW    = $clog2(FRAME_SLOTS + 2);
    localparam int DEPTH = NUM_TRACKERS * FRAME_SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [LW-1:0] NO_FRAME_LEN = LW'(FRAME_SLOTS + 1);
    localparam logic [LW-1:0] FULL_LEN     = LW'(FRAME_SLOTS);
    localparam logic [AW-1:0] ROW_STRIDE   = AW'(FRAME_SLOTS);

    // item moving from the memory access stage into the compare stage
    typedef struct packed {
        logic              clear;
        logic              first;
        logic              last;
        logic              wrote;
        status_t           disp;
        logic [TW-1:0]     trk;
        logic [LW-1:0]     pos;
        logic [LW-1:0]     len;
        logic [SLOT_W-1:0] val;
    } s2_t;

    // configuration
    logic [MASK_W-1:0]     mask_reg;
    logic [UNIVERSE_W-1:0] uni_reg [MAX_TRACKERS];

    // frame tracking in the access stage
    logic [LW-1:0] pos_reg;
    logic [TW-1:0] trk_reg;
    status_t       disp_reg;

    // compare stage
    logic          s2_valid_reg;
    s2_t           s2_reg;
    logic          diff_reg;

    // per-tracker statistics
    logic [LW-1:0]      min_len_reg    [NUM_TRACKERS];
    logic [LW-1:0]      max_len_reg    [NUM_TRACKERS];
    logic [COUNT_W-1:0] frame_cnt_reg  [NUM_TRACKERS];
    logic [COUNT_W-1:0] change_cnt_reg [NUM_TRACKERS];
    logic [LW-1:0]      stored_len_reg [NUM_TRACKERS];

    // report register
    logic                 out_valid_reg;
    status_t              status_reg;
    logic [TRK_IDX_W-1:0] trk_out_reg;
    logic [COUNT_W-1:0]   frames_reg;
    logic [COUNT_W-1:0]   changes_reg;
    logic [LEN_W-1:0]     short_reg;
    logic [LEN_W-1:0]     long_reg;
    logic                 changed_reg;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            for (int i = 0; i < MAX_TRACKERS; i++)
            begin
                uni_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                CFG_TRACKED_MASK:
                begin
                    mask_reg <= cfg_data[MASK_W-1:0];
                end
                [CFG_UNIVERSE_0:CFG_UNIVERSE_3]:
                begin
                    uni_reg[2'(cfg_index - CFG_UNIVERSE_0)] <= cfg_data[UNIVERSE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // access stage: disposition on the first slot, memory read and write
    // ------------------------------------------------------------------
    logic          acc;
    logic          first;
    logic          hit;
    logic [TW-1:0] hit_idx;
    status_t       disp_now;
    logic [TW-1:0] trk_now;
    logic          in_range;
    logic [LW-1:0] pos_inc;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [SLOT_W-1:0] mem_rdata;
    logic          s2_adv;

    assign acc = slots.valid && slots.ready;
    assign first = (pos_reg == '0);

    // lowest enabled tracker with a matching universe wins
    always_comb
    begin
        hit = 1'b0;
        hit_idx = '0;
        for (int i = NUM_TRACKERS - 1; i >= 0; i--)
        begin
            if (mask_reg[i] && (uni_reg[i] == slots.universe))
            begin
                hit = 1'b1;
                hit_idx = TW'(i);
            end
        end
    end

    always_comb
    begin
        disp_now = disp_reg;
        trk_now = trk_reg;
        if (first)
        begin
            if (slots.frame_error)
            begin
                disp_now = STATUS_ERROR;
                trk_now = '0;
            end
            else if (hit)
            begin
                disp_now = STATUS_COUNTED;
                trk_now = hit_idx;
            end
            else
            begin
                disp_now = STATUS_UNKNOWN;
                trk_now = '0;
            end
        end
    end

    // bytes past the frame capacity are dropped, the length stays put
    assign in_range = (pos_reg < FULL_LEN);
    assign pos_inc = in_range ? pos_reg + LW'(1) : pos_reg;

    assign mem_we = acc && !slots.cmd && in_range && (disp_now == STATUS_COUNTED);
    assign mem_addr = AW'(trk_now) * ROW_STRIDE + AW'(pos_reg);

    dmxfs_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .rd_en (acc),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (slots.slot_value),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            trk_reg <= '0;
            disp_reg <= STATUS_COUNTED;
        end
        else if (acc && !slots.cmd)
        begin
            disp_reg <= disp_now;
            trk_reg <= trk_now;
            pos_reg <= slots.last_slot ? '0 : pos_inc;
        end
    end

    // ------------------------------------------------------------------
    // compare stage: byte compare against the old contents, stats update
    // ------------------------------------------------------------------
    assign slots.ready = !s2_valid_reg || s2_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (slots.ready)
        begin
            s2_valid_reg <= slots.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s2_reg.clear <= slots.cmd;
            s2_reg.first <= first;
            s2_reg.last <= slots.last_slot;
            s2_reg.wrote <= in_range && (disp_now == STATUS_COUNTED);
            s2_reg.disp <= disp_now;
            s2_reg.trk <= trk_now;
            s2_reg.pos <= pos_reg;
            s2_reg.len <= pos_inc;
            s2_reg.val <= slots.slot_value;
        end
    end

    logic [LW-1:0]      sl;
    logic [LW-1:0]      cur_min;
    logic [LW-1:0]      cur_max;
    logic [COUNT_W-1:0] cur_fc;
    logic [COUNT_W-1:0] cur_cc;
    logic               byte_diff;
    logic               diff_acc;
    logic               has_result;
    logic               counted;
    logic [LW-1:0]      new_min;
    logic [LW-1:0]      new_max;
    logic [COUNT_W-1:0] new_fc;
    logic [COUNT_W-1:0] new_cc;
    logic               changed;

    assign sl      = stored_len_reg[s2_reg.trk];
    assign cur_min = min_len_reg[s2_reg.trk];
    assign cur_max = max_len_reg[s2_reg.trk];
    assign cur_fc  = frame_cnt_reg[s2_reg.trk];
    assign cur_cc  = change_cnt_reg[s2_reg.trk];

    // a slot beyond the stored frame always differs
    assign byte_diff = s2_reg.wrote && ((s2_reg.pos >= sl) || (mem_rdata != s2_reg.val));
    assign diff_acc = (s2_reg.first ? 1'b0 : diff_reg) | byte_diff;

    assign has_result = !s2_reg.clear && s2_reg.last;
    assign counted = (s2_reg.disp == STATUS_COUNTED);

    assign new_min = (s2_reg.len < cur_min) ? s2_reg.len : cur_min;
    assign new_max = (s2_reg.len > cur_max) ? s2_reg.len : cur_max;
    assign new_fc = sat_inc(cur_fc);
    // first frame of a tracker is only stored
    assign changed = (sl != '0) && (diff_acc || (s2_reg.len != sl));
    assign new_cc = changed ? sat_inc(cur_cc) : cur_cc;

    assign s2_adv = s2_valid_reg && (!has_result || !out_valid_reg || stats.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg <= 1'b0;
            for (int i = 0; i < NUM_TRACKERS; i++)
            begin
                min_len_reg[i] <= NO_FRAME_LEN;
                max_len_reg[i] <= '0;
                frame_cnt_reg[i] <= '0;
                change_cnt_reg[i] <= '0;
                stored_len_reg[i] <= '0;
            end
        end
        else if (s2_adv)
        begin
            if (s2_reg.clear)
            begin
                // stored frames and lengths survive a clear
                for (int i = 0; i < NUM_TRACKERS; i++)
                begin
                    min_len_reg[i] <= NO_FRAME_LEN;
                    max_len_reg[i] <= '0;
                    frame_cnt_reg[i] <= '0;
                    change_cnt_reg[i] <= '0;
                end
            end
            else
            begin
                diff_reg <= diff_acc;
                if (s2_reg.last && counted)
                begin
                    min_len_reg[s2_reg.trk] <= new_min;
                    max_len_reg[s2_reg.trk] <= new_max;
                    frame_cnt_reg[s2_reg.trk] <= new_fc;
                    change_cnt_reg[s2_reg.trk] <= new_cc;
                    stored_len_reg[s2_reg.trk] <= s2_reg.len;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // report register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (stats.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && has_result)
        begin
            status_reg <= s2_reg.disp;
            if (counted)
            begin
                trk_out_reg <= TRK_IDX_W'(s2_reg.trk);
                frames_reg <= new_fc;
                changes_reg <= new_cc;
                short_reg <= LEN_W'(new_min);
                long_reg <= LEN_W'(new_max);
                changed_reg <= changed;
            end
            else
            begin
                // ignored frames report nothing but their status
                trk_out_reg <= '0;
                frames_reg <= '0;
                changes_reg <= '0;
                short_reg <= '0;
                long_reg <= '0;
                changed_reg <= 1'b0;
            end
        end
    end

    assign stats.valid           = out_valid_reg;
    assign stats.status          = status_reg;
    assign stats.tracker_index   = trk_out_reg;
    assign stats.frames_seen     = frames_reg;
    assign stats.changes_seen    = changes_reg;
    assign stats.shortest_length = short_reg;
    assign stats.longest_length  = long_reg;
    assign stats.frame_changed   = changed_reg;

`ifndef SYNTHESIS
    // the compare stage only waits behind a full report register
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_adv) |-> (out_valid_reg && !stats.ready))
        else $error("compare stage stalled without a pending report");

    a_pos_bound : assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= FULL_LEN)
        else $error("slot position past frame capacity");

    a_len_order : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STATUS_COUNTED))
            |-> ((short_reg <= long_reg) && (short_reg != '0)))
        else $error("counted frame reports an empty length range");

    a_change_count : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STATUS_COUNTED)) |-> (changes_reg <= frames_reg))
        else $error("more changes than frames");

    a_ignored_clean : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_COUNTED))
            |-> ((frames_reg == '0) && (changes_reg == '0) && !changed_reg))
        else $error("ignored frame carries statistics");
`endif

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the frame statistics monitor: slot transactions go
// in through a queue-fed driver, a behavioural tracker predicts each frame
// report, and a monitor compares every report field by field
// ----------------------------------------------------------------------------

module tb;
    import dmxfs_pkg::*;

    localparam int NUM_TRACKERS = 4;
    localparam int FRAME_SLOTS  = 512;
    localparam int NO_FRAME_LEN = FRAME_SLOTS + 1;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 90;
    localparam int REPORT_LIMIT = 10;
    localparam int REPLAY_MAX   = 64;

    // slot transaction kinds
    localparam logic CMD_SLOT  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // index beyond the register map, writes to it must be ignored
    localparam cfg_index_t CFG_NONE = 3'd7;

    typedef struct packed {
        logic                  cmd;
        logic [UNIVERSE_W-1:0] universe;
        logic [SLOT_W-1:0]     slot_value;
        logic                  last_slot;
        logic                  frame_error;
    } slot_txn_t;

    typedef struct packed {
        status_t              status;
        logic [TRK_IDX_W-1:0] tracker_index;
        logic [COUNT_W-1:0]   frames_seen;
        logic [COUNT_W-1:0]   changes_seen;
        logic [LEN_W-1:0]     shortest_length;
        logic [LEN_W-1:0]     longest_length;
        logic                 frame_changed;
    } frame_report_t;

    typedef logic [SLOT_W-1:0] frame_body_t[$];
    typedef logic [UNIVERSE_W-1:0] universe_set_t[NUM_TRACKERS];

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dmxfs_in_if  slots_ch();
    dmxfs_out_if stats_ch();

    dmx_frame_stats_monitor #(
        .NUM_TRACKERS (NUM_TRACKERS),
        .FRAME_SLOTS  (FRAME_SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .slots     (slots_ch),
        .stats     (stats_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // register mirror, shared by the tracker model and the frame generator
    // ------------------------------------------------------------------------
    logic [MASK_W-1:0]     cfg_mask;
    logic [UNIVERSE_W-1:0] cfg_universe [NUM_TRACKERS];

    // ------------------------------------------------------------------------
    // tracker model state
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0]   shortest   [NUM_TRACKERS];
    logic [LEN_W-1:0]   longest    [NUM_TRACKERS];
    logic [LEN_W-1:0]   stored_len [NUM_TRACKERS];
    logic [COUNT_W-1:0] frame_cnt  [NUM_TRACKERS];
    logic [COUNT_W-1:0] change_cnt [NUM_TRACKERS];
    logic [SLOT_W-1:0]  frame_mem  [NUM_TRACKERS][FRAME_SLOTS];
    int                 slot_pos;
    logic               frame_differs;
    int                 frame_tracker;
    status_t            frame_status;

    frame_report_t awaited_reports[$];
    slot_txn_t     slot_backlog[$];

    // generator view of the frame each tracker will hold once the backlog drains
    logic [SLOT_W-1:0] sent_frame [NUM_TRACKERS][$];

    slot_txn_t   in_flight;
    int          gap_left;
    int          stall_left;
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    logic        sender_gaps;
    logic        receiver_stalls;
    logic        hold_off;
    logic        hold_request = 1'b0;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // lowest enabled tracker watching this universe, -1 when none
    function automatic int taker_of(input logic [UNIVERSE_W-1:0] uni);
        int i;
        for (i = 0; i < NUM_TRACKERS; i++)
            if (cfg_mask[i] && cfg_universe[i] == uni)
                return i;
        return -1;
    endfunction

    function automatic void clear_statistics();
        int i;
        for (i = 0; i < NUM_TRACKERS; i++)
        begin
            shortest[i]   = LEN_W'(NO_FRAME_LEN);
            longest[i]    = '0;
            frame_cnt[i]  = '0;
            change_cnt[i] = '0;
        end
    endfunction

    // most idles short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // statistics clear, every other field random and ignored
    function automatic slot_txn_t clear_txn();
        slot_txn_t s;
        s.cmd         = CMD_CLEAR;
        s.universe    = UNIVERSE_W'($urandom);
        s.slot_value  = SLOT_W'($urandom);
        s.last_slot   = 1'($urandom);
        s.frame_error = 1'($urandom);
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // tracker model: one accepted slot transaction in, at most one report out
    // ------------------------------------------------------------------------
    task automatic track_slot(input slot_txn_t s);
        frame_report_t r;
        int            frame_len;
        int            t;
        logic          changed;
        if (s.cmd == CMD_CLEAR)
        begin
            // stored frames and a frame in progress survive the clear
            clear_statistics();
            return;
        end
        if (slot_pos == 0)
        begin
            // disposition fixed on the first slot, error wins over unknown
            frame_differs = 1'b0;
            frame_tracker = 0;
            if (s.frame_error)
                frame_status = STATUS_ERROR;
            else if (taker_of(s.universe) < 0)
                frame_status = STATUS_UNKNOWN;
            else
            begin
                frame_status  = STATUS_COUNTED;
                frame_tracker = taker_of(s.universe);
            end
        end
        t = frame_tracker;
        // bytes past the frame size are dropped
        if (slot_pos < FRAME_SLOTS)
        begin
            if (frame_status == STATUS_COUNTED)
            begin
                if (slot_pos >= stored_len[t] || frame_mem[t][slot_pos] != s.slot_value)
                    frame_differs = 1'b1;
                frame_mem[t][slot_pos] = s.slot_value;
            end
            slot_pos++;
        end
        if (!s.last_slot)
            return;
        frame_len = slot_pos;
        slot_pos  = 0;
        r         = '0;
        r.status  = frame_status;
        if (frame_status == STATUS_COUNTED)
        begin
            if (LEN_W'(frame_len) < shortest[t])
                shortest[t] = LEN_W'(frame_len);
            if (LEN_W'(frame_len) > longest[t])
                longest[t] = LEN_W'(frame_len);
            frame_cnt[t] = bump(frame_cnt[t]);
            // a tracker's first frame is only stored
            changed = 1'b0;
            if (stored_len[t] != 0)
            begin
                changed = frame_differs || LEN_W'(frame_len) != stored_len[t];
                if (changed)
                    change_cnt[t] = bump(change_cnt[t]);
            end
            stored_len[t]     = LEN_W'(frame_len);
            r.tracker_index   = TRK_IDX_W'(t);
            r.frames_seen     = frame_cnt[t];
            r.changes_seen    = change_cnt[t];
            r.shortest_length = shortest[t];
            r.longest_length  = longest[t];
            r.frame_changed   = changed;
        end
        awaited_reports.insert(awaited_reports.size(), r);
    endtask

    // ------------------------------------------------------------------------
    // clock and timeout
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL dmx_frame_stats_monitor");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // slot driver: offers the backlog one transaction at a time, feeds every
    // accepted transaction to the tracker model
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : slot_driver
        if (!rst_n)
        begin
            slots_ch.valid       <= 1'b0;
            slots_ch.cmd         <= CMD_SLOT;
            slots_ch.universe    <= '0;
            slots_ch.slot_value  <= '0;
            slots_ch.last_slot   <= 1'b0;
            slots_ch.frame_error <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (slots_ch.valid && slots_ch.ready)
            begin
                track_slot(in_flight);
                gap_left = sender_gaps ? pick_gap() : 0;
            end
            // valid set once per edge, so a back-to-back offer never drops it
            if (!slots_ch.valid || slots_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    slots_ch.valid <= 1'b0;
                end
                else if (slot_backlog.size() != 0)
                begin
                    in_flight = slot_backlog.pop_front();
                    slots_ch.valid       <= 1'b1;
                    slots_ch.cmd         <= in_flight.cmd;
                    slots_ch.universe    <= in_flight.universe;
                    slots_ch.slot_value  <= in_flight.slot_value;
                    slots_ch.last_slot   <= in_flight.last_slot;
                    slots_ch.frame_error <= in_flight.frame_error;
                end
                else
                    slots_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // report monitor: checks each accepted report against the oldest
    // prediction, and drives ready with random stalls
    // ------------------------------------------------------------------------
    task automatic check_field(input string field, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : report_monitor
        frame_report_t want;
        if (!rst_n)
        begin
            stats_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (stats_ch.valid && stats_ch.ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("report with none expected: status %0d frames %0d",
                                 stats_ch.status, stats_ch.frames_seen);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    check_field("status", COUNT_W'(want.status), COUNT_W'(stats_ch.status));
                    check_field("tracker_index", COUNT_W'(want.tracker_index),
                                COUNT_W'(stats_ch.tracker_index));
                    check_field("frames_seen", want.frames_seen, stats_ch.frames_seen);
                    check_field("changes_seen", want.changes_seen, stats_ch.changes_seen);
                    check_field("shortest_length", COUNT_W'(want.shortest_length),
                                COUNT_W'(stats_ch.shortest_length));
                    check_field("longest_length", COUNT_W'(want.longest_length),
                                COUNT_W'(stats_ch.longest_length));
                    check_field("frame_changed", COUNT_W'(want.frame_changed),
                                COUNT_W'(stats_ch.frame_changed));
                end
            end
            if (hold_off)
                stats_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                stats_ch.ready <= 1'b0;
            end
            else
            begin
                stats_ch.ready <= 1'b1;
                if (receiver_stalls)
                    stall_left = pick_gap();
            end
        end
    end

    // long receiver hold-off, so the block fills up and pushes back on slots
    initial
    begin : receiver_hold_off
        hold_off = 1'b0;
        wait (hold_request);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_TRACKED_MASK)
            cfg_mask = data[MASK_W-1:0];
        else if (idx >= CFG_UNIVERSE_0 && idx <= CFG_UNIVERSE_3)
            cfg_universe[idx - CFG_UNIVERSE_0] = data;
    endtask

    task automatic apply_config(input logic [MASK_W-1:0] mask, input universe_set_t ids);
        int i;
        write_register(CFG_TRACKED_MASK, CFG_DATA_W'(mask));
        for (i = 0; i < NUM_TRACKERS; i++)
            write_register(cfg_index_t'(CFG_UNIVERSE_0 + i), ids[i]);
        // must leave the register map untouched
        write_register(CFG_NONE, CFG_DATA_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // wait until every transaction is taken and every report is back
    task automatic settle();
        while (slot_backlog.size() != 0 || slots_ch.valid || awaited_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // one frame into the backlog, a clear slipped in before slot clear_at if >= 0
    task automatic queue_frame(input logic [UNIVERSE_W-1:0] uni, input logic err,
                               input frame_body_t body, input int clear_at);
        slot_txn_t s;
        int        k;
        int        owner;
        owner = err ? -1 : taker_of(uni);
        for (k = 0; k < body.size(); k++)
        begin
            if (k == clear_at)
                slot_backlog.insert(slot_backlog.size(), clear_txn());
            s.cmd        = CMD_SLOT;
            s.slot_value = body[k];
            s.last_slot  = (k == body.size() - 1);
            // universe and error only count on the first slot
            s.universe    = (k == 0) ? uni : UNIVERSE_W'($urandom);
            s.frame_error = (k == 0) ? err : 1'($urandom);
            slot_backlog.insert(slot_backlog.size(), s);
        end
        if (owner >= 0)
        begin
            sent_frame[owner].delete();
            for (k = 0; k < body.size() && k < FRAME_SLOTS; k++)
                sent_frame[owner].insert(sent_frame[owner].size(), body[k]);
        end
    endtask

    // mostly replays of the stored frame, exact or slightly altered, else fresh
    function automatic frame_body_t make_body(input int owner);
        frame_body_t b;
        int          roll;
        int          n;
        int          pos;
        roll = $urandom_range(0, 99);
        if (owner >= 0 && sent_frame[owner].size() != 0
            && sent_frame[owner].size() <= REPLAY_MAX && roll < 70)
        begin
            b = sent_frame[owner];
            if (roll >= 45 && roll < 60)
            begin
                pos    = $urandom_range(0, b.size() - 1);
                b[pos] = b[pos] ^ SLOT_W'($urandom_range(1, 255));
            end
            else if (roll >= 60)
            begin
                if (b.size() > 1 && $urandom_range(0, 1) == 1)
                    void'(b.pop_back());
                else
                    b.insert(b.size(), SLOT_W'($urandom));
            end
            return b;
        end
        roll = $urandom_range(0, 99);
        if (roll < 85)
            n = $urandom_range(1, 8);
        else if (roll < 97)
            n = $urandom_range(9, 40);
        else
            n = $urandom_range(60, 120);
        repeat (n) b.insert(b.size(), SLOT_W'($urandom));
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        universe_set_t         ids;
        frame_body_t           body;
        logic [MASK_W-1:0]     mask;
        logic [UNIVERSE_W-1:0] uni;
        logic                  err;
        int                    p;
        int                    i;
        int                    kind;
        int                    target;
        int                    fed;
        int                    clear_at;

        cfg_we    = 1'b0;
        cfg_index = CFG_TRACKED_MASK;
        cfg_data  = '0;
        slots_ch.valid       = 1'b0;
        slots_ch.cmd         = CMD_SLOT;
        slots_ch.universe    = '0;
        slots_ch.slot_value  = '0;
        slots_ch.last_slot   = 1'b0;
        slots_ch.frame_error = 1'b0;
        stats_ch.ready       = 1'b0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;

        // model after reset
        cfg_mask = '0;
        for (i = 0; i < NUM_TRACKERS; i++)
        begin
            cfg_universe[i] = '0;
            stored_len[i]   = '0;
        end
        clear_statistics();
        slot_pos      = 0;
        frame_differs = 1'b0;
        frame_tracker = 0;
        frame_status  = STATUS_COUNTED;

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset configuration: nothing tracked, error outranks unknown
        body = '{8'h00};
        queue_frame(32'h0000_0000, 1'b0, body, -1);
        body = '{8'hFF, 8'h00};
        queue_frame(32'hFFFF_FFFF, 1'b1, body, -1);
        settle();

        // all trackers on, slots one and three share a universe
        ids = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 32'hFFFF_FFFF};
        apply_config(4'hF, ids);
        body = '{8'h00};
        queue_frame(32'h0000_0000, 1'b0, body, -1);    // first frame, stored only
        queue_frame(32'h0000_0000, 1'b0, body, -1);    // identical, unchanged
        body = '{8'hFF, 8'hFF};
        queue_frame(32'h0000_0000, 1'b0, body, -1);    // length differs
        body = '{8'hAA, 8'h55, 8'hAA};
        queue_frame(32'hFFFF_FFFF, 1'b1, body, -1);    // tracked but in error
        body = '{8'h80, 8'h01};
        queue_frame(32'hFFFF_FFFF, 1'b0, body, -1);    // lowest slot wins
        slot_backlog.insert(slot_backlog.size(), clear_txn());
        body = '{8'hFF, 8'hFF};
        queue_frame(32'h0000_0000, 1'b0, body, -1);    // counters restart, frame kept
        body = '{8'hFF, 8'h7F};
        queue_frame(32'h0000_0000, 1'b0, body, 1);     // clear in mid-frame
        body = '{8'h3C};
        queue_frame(32'h1234_5678, 1'b0, body, -1);    // unknown universe
        settle();

        // random phases with varying register settings
        for (p = 0; p < PHASES; p++)
        begin
            for (i = 0; i < NUM_TRACKERS; i++)
            begin
                kind = $urandom_range(0, 3);
                if (kind == 0)
                    ids[i] = '0;
                else if (kind == 1)
                    ids[i] = '1;
                else if (kind == 2 && i > 0)
                    ids[i] = ids[i - 1];
                else
                    ids[i] = UNIVERSE_W'($urandom);
            end
            case (p)
                0:       mask = 4'hF;
                1:       mask = 4'h0;
                3:       mask = 4'hA;
                default: mask = MASK_W'($urandom_range(1, 15));
            endcase
            if (p == 0)
                ids = '{32'h0000_0000, 32'hFFFF_FFFF, UNIVERSE_W'($urandom), 32'hFFFF_FFFF};
            // one phase with no idling on either side
            sender_gaps     = (p != 3);
            receiver_stalls = (p != 3);
            apply_config(mask, ids);
            target = (mask == 0) ? PHASE_ITEMS / 5 : PHASE_ITEMS;
            fed    = 0;
            while (fed < target)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 4)
                    slot_backlog.insert(slot_backlog.size(), clear_txn());
                else
                begin
                    if (kind < 78)
                        uni = cfg_universe[$urandom_range(0, NUM_TRACKERS - 1)];
                    else if (kind < 90 || kind >= 95)
                        uni = UNIVERSE_W'($urandom);
                    else
                        uni = cfg_universe[$urandom_range(0, NUM_TRACKERS - 1)];
                    err      = (kind >= 90);
                    body     = make_body(err ? -1 : taker_of(uni));
                    clear_at = ($urandom_range(0, 99) < 4) ?
                               $urandom_range(0, body.size() - 1) : -1;
                    queue_frame(uni, err, body, clear_at);
                    fed += body.size();
                end
            end
            settle();
        end

        // back pressure: single-slot frames offered without pause while the
        // receiver holds off for a long stretch
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        ids = '{32'h0F0F_F0F0, 32'hF0F0_0F0F, 32'h0000_0001, 32'h8000_0000};
        apply_config(4'h1, ids);
        hold_request = 1'b1;
        repeat (40)
        begin
            body = '{SLOT_W'($urandom)};
            queue_frame(32'h0F0F_F0F0, 1'b0, body, -1);
        end
        settle();

        if (mismatches == 0)
            $display("PASS dmx_frame_stats_monitor");
        else
            $display("FAIL dmx_frame_stats_monitor");
        $finish;
    end

endmodule

>>> files.f
rtl/dmxfs_pkg.sv
rtl/dmxfs_if.sv
rtl/dmxfs_store.sv
rtl/dmx_frame_stats_monitor.sv
bench/tb.sv
